// ===== hdl/tsr_pkg.sv =====
// Shared types, constants and parse phases of the ClientHello name rewriter.
package tsr_pkg;

   // Name buffer geometry
   localparam int MaxNameBytes = 256;
   localparam int NameAddrW    = $clog2(MaxNameBytes);
   localparam int NameCountW   = NameAddrW + 1;

   // Offsets into the packet are kept at this width
   localparam int OffW = 19;
   localparam int PosW = 17;

   // TLS header codes and layout
   localparam logic [7:0]      RecTypeHandshake  = 8'h16;
   localparam logic [7:0]      HsTypeClientHello = 8'h01;
   localparam logic [OffW-1:0] RecHdrLen         = OffW'(5);
   localparam logic [OffW-1:0] RandomLen         = OffW'(32);
   localparam logic [OffW-1:0] SidLenPos         = RecHdrLen + OffW'(4) + OffW'(2) + RandomLen;

   // Parse phases
   typedef enum logic [3:0] {
      PH_PREFIX  = 4'd0,
      PH_SID     = 4'd1,
      PH_CIPH_HI = 4'd2,
      PH_CIPH_LO = 4'd3,
      PH_COMP    = 4'd4,
      PH_EXTL_HI = 4'd5,
      PH_EXTL_LO = 4'd6,
      PH_TYPE_HI = 4'd7,
      PH_TYPE_LO = 4'd8,
      PH_LEN_HI  = 4'd9,
      PH_LEN_LO  = 4'd10,
      PH_HLEN_HI = 4'd11,
      PH_HLEN_LO = 4'd12,
      PH_HOST    = 4'd13,
      PH_DONE    = 4'd14
   } phase_type;

   // Input item
   typedef struct packed {
      logic        action;
      logic [7:0]  data_byte;
      logic [15:0] packet_length;
      logic [7:0]  expected_length;
   } req_type;

   // Result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_packet;
      logic       verdict;
      logic       was_replaced;
   } rsp_type;

   // Name buffer access from the parser
   typedef struct packed {
      logic                 we;
      logic [NameAddrW-1:0] waddr;
      logic [7:0]           wdata;
      logic                 re;
      logic [NameAddrW-1:0] raddr;
   } ram_ctl_type;

   // Parser result handed to the read stage
   typedef struct packed {
      logic       is_result;
      logic [7:0] out_byte;
      logic       use_ram;
      logic       eop;
      logic       verdict;
      logic       replaced;
   } stage_type;

endpackage

// ===== hdl/tsr_ram.sv =====
// Generic single-port-write, registered-read RAM.
module tsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/tsr_parser.sv =====
// Header parser: per-packet state, name loads and hostname read requests.
module tsr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  tsr_pkg::req_type     req,
   output tsr_pkg::ram_ctl_type ram_ctl,
   output tsr_pkg::stage_type   res
);

   localparam int OffW = tsr_pkg::OffW;
   localparam int PosW = tsr_pkg::PosW;
   localparam int NcW  = tsr_pkg::NameCountW;

   logic [NcW-1:0]        name_count_ff, name_count_in;
   logic [PosW-1:0]       pos_ff, pos_in;
   tsr_pkg::phase_type    phase_ff, phase_in;
   logic [OffW-1:0]       nfo_ff, nfo_in;
   logic [OffW-1:0]       ext_end_ff, ext_end_in;
   logic [15:0]           acc_ff, acc_in;
   logic                  rejected_ff, rejected_in;
   logic                  replaced_ff, replaced_in;

   logic [OffW-1:0] pos_w;
   logic [OffW-1:0] b_w;
   logic [OffW-1:0] host_idx;
   logic [15:0]     acc_full;
   logic            skip;
   logic            eop;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         name_count_ff <= '0;
         pos_ff        <= '0;
         phase_ff      <= tsr_pkg::PH_PREFIX;
         nfo_ff        <= '0;
         ext_end_ff    <= '0;
         acc_ff        <= '0;
         rejected_ff   <= 1'b0;
         replaced_ff   <= 1'b0;
      end else begin
         name_count_ff <= name_count_in;
         pos_ff        <= pos_in;
         phase_ff      <= phase_in;
         nfo_ff        <= nfo_in;
         ext_end_ff    <= ext_end_in;
         acc_ff        <= acc_in;
         rejected_ff   <= rejected_in;
         replaced_ff   <= replaced_in;
      end
   end

   // Next state, name buffer access and the per-byte result
   always_comb begin
      name_count_in = name_count_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      nfo_in        = nfo_ff;
      ext_end_in    = ext_end_ff;
      acc_in        = acc_ff;
      rejected_in   = rejected_ff;
      replaced_in   = replaced_ff;

      pos_w    = OffW'(pos_ff);
      b_w      = OffW'(req.data_byte);
      host_idx = pos_w - nfo_ff;
      acc_full = {acc_ff[15:8], req.data_byte};
      skip     = (phase_ff >= tsr_pkg::PH_SID) && (phase_ff <= tsr_pkg::PH_HLEN_LO) &&
                 (pos_w != nfo_ff);
      eop      = ((PosW+1)'(pos_ff) + (PosW+1)'(1)) >= (PosW+1)'(req.packet_length);

      ram_ctl       = '0;
      ram_ctl.waddr = name_count_ff[tsr_pkg::NameAddrW-1:0];
      ram_ctl.wdata = req.data_byte;
      ram_ctl.raddr = host_idx[tsr_pkg::NameAddrW-1:0];

      res           = '0;
      res.out_byte  = req.data_byte;

      if (accept && !req.action) begin
         // Name load: append while there is room
         if (name_count_ff < NcW'(tsr_pkg::MaxNameBytes)) begin
            ram_ctl.we    = 1'b1;
            name_count_in = name_count_ff + NcW'(1);
         end
      end else if (accept) begin
         res.is_result = 1'b1;
         if (!skip) begin
            unique case (phase_ff) inside
               tsr_pkg::PH_PREFIX: begin
                  if ((pos_w == '0 && req.data_byte != tsr_pkg::RecTypeHandshake) ||
                      (pos_w == tsr_pkg::RecHdrLen &&
                       req.data_byte != tsr_pkg::HsTypeClientHello)) begin
                     rejected_in = 1'b1;
                     phase_in    = tsr_pkg::PH_DONE;
                  end else if (pos_w + OffW'(1) >= tsr_pkg::SidLenPos) begin
                     phase_in = tsr_pkg::PH_SID;
                     nfo_in   = tsr_pkg::SidLenPos;
                  end
               end
               tsr_pkg::PH_SID: begin
                  nfo_in   = pos_w + OffW'(1) + b_w;
                  phase_in = tsr_pkg::PH_CIPH_HI;
               end
               tsr_pkg::PH_CIPH_HI, tsr_pkg::PH_EXTL_HI,
               tsr_pkg::PH_LEN_HI, tsr_pkg::PH_HLEN_HI: begin
                  acc_in   = {req.data_byte, 8'h00};
                  nfo_in   = pos_w + OffW'(1);
                  phase_in = tsr_pkg::phase_type'(phase_ff + 4'd1);
               end
               tsr_pkg::PH_CIPH_LO: begin
                  acc_in   = acc_full;
                  nfo_in   = pos_w + OffW'(1) + OffW'(acc_full);
                  phase_in = tsr_pkg::PH_COMP;
               end
               tsr_pkg::PH_COMP: begin
                  nfo_in   = pos_w + OffW'(1) + b_w;
                  phase_in = tsr_pkg::PH_EXTL_HI;
               end
               tsr_pkg::PH_EXTL_LO: begin
                  acc_in     = acc_full;
                  ext_end_in = pos_w + OffW'(1) + OffW'(acc_full);
                  nfo_in     = pos_w + OffW'(1);
                  phase_in   = tsr_pkg::PH_TYPE_HI;
               end
               tsr_pkg::PH_TYPE_HI: begin
                  // Header past the end of the extension block ends the walk
                  if (pos_w + OffW'(4) > ext_end_ff) begin
                     phase_in = tsr_pkg::PH_DONE;
                  end else begin
                     acc_in   = {req.data_byte, 8'h00};
                     nfo_in   = pos_w + OffW'(1);
                     phase_in = tsr_pkg::PH_TYPE_LO;
                  end
               end
               tsr_pkg::PH_TYPE_LO: begin
                  acc_in = acc_full;
                  if (acc_full == '0) begin
                     // Server name: skip ext length, list length, name type
                     nfo_in   = pos_w + OffW'(6);
                     phase_in = tsr_pkg::PH_HLEN_HI;
                  end else begin
                     nfo_in   = pos_w + OffW'(1);
                     phase_in = tsr_pkg::PH_LEN_HI;
                  end
               end
               tsr_pkg::PH_LEN_LO: begin
                  acc_in   = acc_full;
                  nfo_in   = pos_w + OffW'(1) + OffW'(acc_full);
                  phase_in = tsr_pkg::PH_TYPE_HI;
               end
               tsr_pkg::PH_HLEN_LO: begin
                  acc_in = acc_full;
                  nfo_in = pos_w + OffW'(1);
                  if (acc_full != '0 && acc_full == 16'(req.expected_length) &&
                      pos_w + OffW'(1) + OffW'(acc_full) <= OffW'(req.packet_length)) begin
                     phase_in = tsr_pkg::PH_HOST;
                  end else begin
                     phase_in = tsr_pkg::PH_DONE;
                  end
               end
               tsr_pkg::PH_HOST: begin
                  // Hostname byte: copy from the name buffer, clipped
                  if (host_idx < OffW'(acc_ff) && host_idx < OffW'(name_count_ff) &&
                      host_idx < OffW'(tsr_pkg::MaxNameBytes)) begin
                     ram_ctl.re  = 1'b1;
                     res.use_ram = 1'b1;
                     replaced_in = 1'b1;
                  end
                  if (host_idx + OffW'(1) >= OffW'(acc_ff)) begin
                     phase_in = tsr_pkg::PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end

         // Final byte: report and clear per-packet state
         res.eop = eop;
         if (eop) begin
            res.verdict  = rejected_in || (phase_in <= tsr_pkg::PH_EXTL_LO) ||
                           (phase_in == tsr_pkg::PH_HLEN_HI) ||
                           (phase_in == tsr_pkg::PH_HLEN_LO);
            res.replaced = replaced_in;
            name_count_in = '0;
            pos_in        = '0;
            phase_in      = tsr_pkg::PH_PREFIX;
            nfo_in        = '0;
            ext_end_in    = '0;
            acc_in        = '0;
            rejected_in   = 1'b0;
            replaced_in   = 1'b0;
         end else begin
            pos_in = pos_ff + PosW'(1);
         end
      end
   end

endmodule

// ===== hdl/tsr_out_fifo.sv =====
// Two-entry result queue between the read stage and the result channel.
module tsr_out_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tsr_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsr_pkg::rsp_type rsp_data
);

   tsr_pkg::rsp_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/tls_hello_sni_rewriter.sv =====
// Top level of the ClientHello server-name rewriter.
//
//   channel   direction  payload              handshake
//   req       in         tsr_pkg::req_type    req_valid / req_stall
//   rsp       out        tsr_pkg::rsp_type    rsp_valid / rsp_stall
//
// One item per cycle is taken while req_stall is low; a packet byte's result
// passes from the parser through the name buffer read stage and the output queue.
// The name buffer read stage and the output queue are the registers on that path;
// name loads give no result.
// Reset is synchronous and clears the parser and queue; the name buffer
// holds no reset value and needs no clearing pass.
// req_stall rises only when the read stage and the two-entry queue are full.
module tls_hello_sni_rewriter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsr_pkg::rsp_type rsp_data
);

   logic                 accept;
   tsr_pkg::ram_ctl_type ram_ctl;
   tsr_pkg::stage_type   stage_res;
   logic [7:0]           ram_rdata;

   logic                 s2_valid_ff, s2_valid_in;
   tsr_pkg::stage_type   s2_ff;
   logic                 fifo_full;
   logic                 s2_adv;
   tsr_pkg::rsp_type     s2_out;

   assign req_stall = s2_valid_ff && fifo_full;
   assign accept    = req_valid && !req_stall;
   assign s2_adv    = s2_valid_ff && !fifo_full;

   tsr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .ram_ctl (ram_ctl),
      .res     (stage_res)
   );

   tsr_ram #(
      .WIDTH (8),
      .DEPTH (tsr_pkg::MaxNameBytes)
   ) u_name_ram (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wdata),
      .re    (ram_ctl.re),
      .raddr (ram_ctl.raddr),
      .rdata (ram_rdata)
   );

   // Read stage: waits for the name buffer data
   always_comb begin
      if (accept && stage_res.is_result) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && stage_res.is_result) begin
         s2_ff <= stage_res;
      end
   end

   // Pick the replacement byte where the hostname was rewritten
   always_comb begin
      s2_out.out_byte      = s2_ff.use_ram ? ram_rdata : s2_ff.out_byte;
      s2_out.end_of_packet = s2_ff.eop;
      s2_out.verdict       = s2_ff.verdict;
      s2_out.was_replaced  = s2_ff.replaced;
   end

   tsr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_adv),
      .push_data (s2_out),
      .full      (fifo_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/tsr_checker.sv =====
// Port-level checks for the rewriter, bound to the top level.
module tsr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input tsr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tsr_pkg::rsp_type rsp_data
);

   // A stalled input item stays presented and unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled input item changed");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Outcome fields only on the final byte
   a_flags_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.end_of_packet |-> !rsp_data.verdict && !rsp_data.was_replaced)
      else $error("outcome flags set before end of packet");

   // A rewritten packet was never rejected
   a_replaced_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_replaced |-> !rsp_data.verdict)
      else $error("rewritten packet reported as rejected");

   // Queue is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind tls_hello_sni_rewriter tsr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
